// ===== hdl/stkrev_pkg.sv =====
// stkrev_pkg: shared types and constants for the stack with in-place reverse
// request codes, sequencer states and the default stack depth
// no dependencies
`timescale 1ns / 1ps

package stkrev_pkg;

  // default number of stored words
  localparam int STACK_DEPTH_DEF = 256;

  // data word width, fixed by the interface
  localparam int WORD_W = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_REVERSE = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_REV_RA,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/stkrev_ram.sv =====
// stkrev_ram: generic single-write, single-read RAM with registered read data
// parameters set word width and depth
// no dependencies
`timescale 1ns / 1ps

module stkrev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/stack_with_reverse.sv =====
// stack_with_reverse: bounded lifo stack of signed words with in-place reverse
// uses stkrev_pkg (request codes, states) and stkrev_ram (word store)
`timescale 1ns / 1ps

// A LIFO stack of STACK_DEPTH signed 32-bit words held in one RAM with one
// write port and one registered read port. Each accepted request (push, pop,
// clear or reverse) gives exactly one result word with the popped value (zero
// unless a pop succeeded), the entry count after the operation, an empty flag
// and an error flag (push onto a full stack, pop from an empty one; neither
// changes anything). The block takes one request at a time and in_ready is
// high only while the sequencer is idle; a finished result waits in the
// output register, and one not yet taken holds the sequencer in its emit
// state, holding off the next request. Push, clear and failing requests go
// straight to emit, a pop passes a RAM read state, a reverse of n entries
// swaps floor(n/2) mirrored pairs, each read and written back in four steps
// through the single RAM port pair. The store needs no clearing after reset.
module stack_with_reverse #(
  parameter int STACK_DEPTH = stkrev_pkg::STACK_DEPTH_DEF,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          req_type,
  input  logic signed [stkrev_pkg::WORD_W-1:0] push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [stkrev_pkg::WORD_W-1:0] pop_value,
  output logic [CW-1:0]                       entry_count,
  output logic                                is_empty,
  output logic                                error
);

  localparam int WW = stkrev_pkg::WORD_W;

  stkrev_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] hi, hi_next;
  logic [WW-1:0] tmp, tmp_next;
  logic [WW-1:0] res_pop, res_pop_next;
  logic          res_err, res_err_next;
  logic          out_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  stkrev_ram #(
    .WIDTH (WW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == stkrev_pkg::ST_IDLE);

  // sequencer: next state, datapath updates and ram controls
  always_comb begin
    state_next   = state;
    count_next   = count;
    lo_next      = lo;
    hi_next      = hi;
    tmp_next     = tmp;
    res_pop_next = res_pop;
    res_err_next = res_err;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = count[AW-1:0];
    ram_wdata    = $unsigned(push_value);
    ram_re       = 1'b0;
    ram_raddr    = lo;
    case (state)
      stkrev_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_pop_next = '0;
          res_err_next = 1'b0;
          state_next   = stkrev_pkg::ST_EMIT;
          case (stkrev_pkg::req_t'(req_type))
            stkrev_pkg::REQ_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                res_err_next = 1'b1;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            stkrev_pkg::REQ_POP: begin
              if (count == '0) begin
                res_err_next = 1'b1;
              end else begin
                count_next = count - CW'(1);
                ram_re     = 1'b1;
                ram_raddr  = AW'(count - CW'(1));
                state_next = stkrev_pkg::ST_POP_RD;
              end
            end
            stkrev_pkg::REQ_CLEAR: begin
              count_next = '0;
            end
            default: begin
              // reverse: nothing to swap below two entries
              if (count >= CW'(2)) begin
                lo_next    = '0;
                hi_next    = AW'(count - CW'(1));
                state_next = stkrev_pkg::ST_REV_RA;
              end
            end
          endcase
        end
      end
      stkrev_pkg::ST_POP_RD: begin
        res_pop_next = ram_rdata;
        state_next   = stkrev_pkg::ST_EMIT;
      end
      // swap pair: read low, read high, write low, write high
      stkrev_pkg::ST_REV_RA: begin
        ram_re     = 1'b1;
        ram_raddr  = lo;
        state_next = stkrev_pkg::ST_REV_RB;
      end
      stkrev_pkg::ST_REV_RB: begin
        ram_re     = 1'b1;
        ram_raddr  = hi;
        tmp_next   = ram_rdata;
        state_next = stkrev_pkg::ST_REV_WA;
      end
      stkrev_pkg::ST_REV_WA: begin
        ram_we     = 1'b1;
        ram_waddr  = lo;
        ram_wdata  = ram_rdata;
        state_next = stkrev_pkg::ST_REV_WB;
      end
      stkrev_pkg::ST_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = tmp;
        lo_next   = lo + AW'(1);
        hi_next   = hi - AW'(1);
        if ((lo + AW'(1)) < (hi - AW'(1))) begin
          state_next = stkrev_pkg::ST_REV_RA;
        end else begin
          state_next = stkrev_pkg::ST_EMIT;
        end
      end
      stkrev_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = stkrev_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stkrev_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stkrev_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers and result word
  always_ff @(posedge clk) begin
    lo      <= lo_next;
    hi      <= hi_next;
    tmp     <= tmp_next;
    res_pop <= res_pop_next;
    res_err <= res_err_next;
    if (out_load) begin
      pop_value   <= $signed(res_pop);
      entry_count <= count;
      is_empty    <= (count == '0);
      error       <= res_err;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stored count above depth");

  a_err_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (entry_count == '0 || entry_count == CW'(STACK_DEPTH)))
    else $error("error flagged with stack neither empty nor full");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_rev_order: assert property (@(posedge clk) disable iff (rst)
    (state == stkrev_pkg::ST_REV_RA) |-> (lo < hi))
    else $error("reverse pointers crossed");

  a_rev_count: assert property (@(posedge clk) disable iff (rst)
    (state == stkrev_pkg::ST_REV_WB) |=> $stable(count))
    else $error("count changed during reverse");

endmodule
